### rtl/lvmft_pkg.sv
`default_nettype none
package lvmft_pkg;

  typedef struct packed {
    logic signed [31:0] leg_len;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_z;
    logic signed [31:0] jac_a;
    logic signed [31:0] jac_b;
    logic signed [31:0] jac_c;
    logic signed [31:0] jac_d;
    logic signed [31:0] goal_len;
    logic signed [31:0] support_ff;
    logic signed [31:0] angle_torque;
    logic signed [31:0] leg_speed;
    logic signed [31:0] goal_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] leg_force;
    logic signed [31:0] joint_one_torque;
    logic signed [31:0] joint_two_torque;
    logic signed [31:0] integral_now;
    logic               length_fault;
  } out_item_t;

  localparam int RegCount = 8;
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KD    = 3'd1;
  localparam logic [2:0] REG_KI    = 3'd2;
  localparam logic [2:0] REG_FLIM  = 3'd3;
  localparam logic [2:0] REG_ILIM  = 3'd4;
  localparam logic [2:0] REG_PUSH  = 3'd5;
  localparam logic [2:0] REG_DBAND = 3'd6;
  localparam logic [2:0] REG_KEXT  = 3'd7;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // start strobe from the sequencer to the divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'(S32Max)) return 32'sh7fffffff;
    if (x < 66'(S32Min)) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/lvmft_mul.sv
`default_nettype none
// registered signed Q16.16 product, floor shift
module lvmft_mul
  import lvmft_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [49:0]      p
);
  logic signed [65:0] full;
  assign full = a * b;
  always_ff @(posedge clk) begin
    p <= full[65:16];
  end
endmodule
`default_nettype wire

### rtl/lvmft_div.sv
`default_nettype none
// restoring divider: sat32(trunc(num*65536/den)), den > 0, one bit per cycle
module lvmft_div
  import lvmft_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire div_ctl_t           ctl,
  input  wire logic signed [31:0] num,
  input  wire logic        [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  logic [47:0] rem_q;   // magnitude shifted out MSB first
  logic [32:0] part;
  logic [47:0] q;
  logic [5:0]  cnt;
  logic        neg;
  logic        run;
  logic [32:0] trial;
  logic signed [65:0] sq;

  assign trial = {part[31:0], rem_q[47]} - {1'b0, den};
  assign sq = neg ? -$signed({18'd0, q}) : $signed({18'd0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= 6'd0;
        part <= '0;
        q <= '0;
        neg <= num[31];
        rem_q <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
      end else if (run) begin
        rem_q <= {rem_q[46:0], 1'b0};
        if (!trial[32]) begin
          part <= trial;
          q <= {q[46:0], 1'b1};
        end else begin
          part <= {part[31:0], rem_q[47]};
          q <= {q[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = sat32(sq);
endmodule
`default_nettype wire

### rtl/leg_virtual_model_force_to_torque.sv
`default_nettype none
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | in_item_t
// out     | out | out_valid/out_stall | out_item_t
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// One item at a time. When the length is not positive, the three 48-step serial
// divides and the eight force and torque products are skipped; else the item
// takes the three divides and twelve passes through the shared multiplier.
// The next item is taken once the result has left.
// rst clears the registers, the integral and the control state.
// A stalled result holds; input stalls until the result has left.
module leg_virtual_model_force_to_torque
  import lvmft_pkg::*;
#(
  parameter logic [30:0] RATE_DEADBAND = 31'd655
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [30:0] cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0, S_M1 = 5'd1, S_M2 = 5'd2, S_M3 = 5'd3,
    S_M4 = 5'd4, S_SUM = 5'd5, S_D0 = 5'd6, S_D1 = 5'd7, S_D2 = 5'd8,
    S_P0 = 5'd9, S_P1 = 5'd10, S_P2 = 5'd11, S_P3 = 5'd12,
    S_P4 = 5'd13, S_P5 = 5'd14, S_P6 = 5'd15, S_P7 = 5'd16, S_OUT = 5'd17,
    S_W = 5'd18;

  logic [30:0] regs [RegCount];
  logic [4:0]  state;
  logic [1:0]  sub;
  in_item_t    it;
  logic signed [31:0] err, integ, axial, rx, rz, tq, fx, fz;
  logic signed [65:0] acc;
  logic signed [32:0] ma, mb;
  logic signed [49:0] mp;
  div_ctl_t    dctl;
  logic        ddone;
  logic signed [31:0] dq, dnum;
  logic signed [32:0] errw;

  lvmft_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  lvmft_div u_div (.clk(clk), .rst(rst), .ctl(dctl), .num(dnum),
                   .den(it.leg_len), .done(ddone), .quo(dq));

  assign in_stall = (state != S_IDLE) || out_valid;
  assign errw = 33'(it.goal_len) - 33'(it.leg_len);

  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_M1: begin ma = 33'(regs[REG_KI]); mb = 33'(err); end
      S_M2: begin ma = 33'(regs[REG_KP]); mb = 33'(err); end
      S_M3: begin ma = 33'(regs[REG_KD]); mb = 33'(it.leg_speed); end
      S_M4: begin ma = 33'(regs[REG_KEXT]); mb = 33'(it.goal_rate); end
      S_P0: begin ma = 33'(axial); mb = 33'(rx); end
      S_P1: begin ma = 33'(tq); mb = 33'(rz); end
      S_P2: begin ma = 33'(axial); mb = 33'(rz); end
      S_P3: begin ma = 33'(tq); mb = 33'(rx); end
      S_P4: begin ma = 33'(it.jac_a); mb = 33'(fx); end
      S_P5: begin ma = 33'(it.jac_c); mb = 33'(fz); end
      S_P6: begin ma = 33'(it.jac_b); mb = 33'(fx); end
      S_P7: begin ma = 33'(it.jac_d); mb = 33'(fz); end
      default: ;
    endcase
    case (state)
      S_D1: dnum = it.foot_z;
      S_D2: dnum = it.angle_torque;
      default: dnum = it.foot_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RegCount; i++) regs[i] <= '0;
      state <= S_IDLE;
      out_valid <= 1'b0;
      integ <= '0;
      sub <= '0;
      dctl.start <= 1'b0;
    end else begin
      if (cfg_we) regs[cfg_index] <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      dctl.start <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          it <= in_data; sub <= '0; state <= S_W;
        end
        S_W: begin err <= sat32(66'(errw)); state <= S_M1; end
        // each multiply state holds until the registered product is ready before it advances
        S_M1, S_M2, S_M3, S_M4, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_P7: begin
          sub <= sub + 2'd1;
          if (sub == 2'd1) begin
            sub <= '0;
            state <= state + 5'd1;
            case (state)
              S_M1: begin
                acc <= 66'(integ) + 66'(mp);
              end
              S_M2: begin
                if (acc > 66'($signed({1'b0, regs[REG_ILIM]}))) begin
                  integ <= 32'(regs[REG_ILIM]); acc <= 66'(mp) + 66'(regs[REG_ILIM]);
                end else if (acc < -66'($signed({1'b0, regs[REG_ILIM]}))) begin
                  integ <= -32'(regs[REG_ILIM]); acc <= 66'(mp) - 66'(regs[REG_ILIM]);
                end else begin
                  integ <= acc[31:0]; acc <= 66'(mp) + acc;
                end
              end
              S_M3: acc <= acc - 66'(mp) + 66'(it.support_ff)
                - ((33'(err) < -33'($signed({1'b0, regs[REG_DBAND]})))
                   ? 66'(regs[REG_PUSH]) : 66'sd0);
              S_M4: if ($signed(it.goal_rate) > $signed({1'b0, RATE_DEADBAND}))
                acc <= acc + 66'(mp);
              S_P0: acc <= 66'(mp);
              S_P1: fx <= sat32(acc - 66'(mp));
              S_P2: acc <= 66'(mp);
              S_P3: fz <= sat32(acc + 66'(mp));
              S_P4: acc <= 66'(mp);
              S_P5: begin
                out_data.joint_one_torque <= sat32(acc + 66'(mp));
              end
              S_P6: acc <= 66'(mp);
              S_P7: begin
                out_data.joint_two_torque <= sat32(acc + 66'(mp));
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          if (acc > 66'($signed({1'b0, regs[REG_FLIM]})))
            axial <= 32'(regs[REG_FLIM]);
          else if (acc < -66'($signed({1'b0, regs[REG_FLIM]})))
            axial <= -32'(regs[REG_FLIM]);
          else axial <= acc[31:0];
          if (it.leg_len <= 0) begin
            out_data.joint_one_torque <= '0;
            out_data.joint_two_torque <= '0;
            state <= S_OUT;
          end else begin
            dctl.start <= 1'b1; state <= S_D0;
          end
        end
        S_D0, S_D1, S_D2: if (ddone) begin
          if (state == S_D0) begin rx <= dq; dctl.start <= 1'b1; state <= S_D1; end
          else if (state == S_D1) begin rz <= dq; dctl.start <= 1'b1; state <= S_D2; end
          else begin tq <= dq; state <= S_P0; end
        end
        S_OUT: begin
          out_data.leg_force <= axial;
          out_data.integral_now <= integ;
          out_data.length_fault <= (it.leg_len <= 0);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result lost");
  a_integ_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.integral_now <= $signed({1'b0, regs[REG_ILIM]})))
    else $error("integral over limit");
endmodule
`default_nettype wire
